/* rtl/jbd_pkg.sv */
// Package for the joint bilateral denoiser: constants, item layouts, divider
// request/response types and the exponential weight table built at elaboration.
// No dependencies.
package jbd_pkg;

	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 512;
	localparam int RADIUS_DEF     = 8;

	localparam int EXP_TABLE_SIZE = 256;
	localparam int EXP_IW         = $clog2(EXP_TABLE_SIZE);
	localparam logic [63:0] E_INV_Q32 = 64'd1580030169;

	localparam logic [15:0] LUM_R = 16'd13932;
	localparam logic [15:0] LUM_G = 16'd46872;
	localparam logic [15:0] LUM_B = 16'd4732;
	localparam logic [2:0][15:0] LUM_COEF = {LUM_B, LUM_G, LUM_R};

	localparam int DIV_W  = 33;
	localparam int QUO_W  = 24;
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEPS_TONE = 5'd24;
	localparam logic [STEP_W-1:0] STEPS_AVG  = 5'd24;
	localparam logic [STEP_W-1:0] STEPS_INV  = 5'd16;

	typedef enum logic [2:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_SPATIAL      = 3'd2,
		CFG_ALBEDO       = 3'd3,
		CFG_NORMAL       = 3'd4
	} cfg_index_t;

	typedef enum logic {
		OP_WRITE   = 1'b0,
		OP_COMPUTE = 1'b1
	} op_t;

	typedef struct packed {
		logic [2:0][15:0] color;
		logic [2:0][11:0] albedo;
		logic [2:0][15:0] normal;
	} pixel_t;

	typedef struct packed {
		logic                       start;
		logic [STEP_W-1:0]          steps;
		logic [DIV_W-1:0]           divisor;
		logic [2:0][DIV_W-1:0]      rem_init;
		logic [2:0][QUO_W-1:0]      low_init;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [2:0][QUO_W-1:0] quot;
	} div_rsp_t;

	typedef logic [16:0] exp_tab_t [EXP_TABLE_SIZE];

	// exp(-16*i/EXP_TABLE_SIZE) in Q16, Taylor series on the fraction in Q32
	function automatic logic [16:0] exp_entry(int unsigned i);
		logic [63:0]        x;
		logic [63:0]        whole;
		logic [63:0]        frac;
		logic [63:0]        term;
		logic [63:0]        r;
		logic [127:0]       prod;
		logic signed [63:0] sum;
		x     = (64'(i) << 36) / 64'(EXP_TABLE_SIZE);
		whole = x >> 32;
		frac  = {32'd0, x[31:0]};
		term  = 64'h1_0000_0000;
		sum   = 64'sh1_0000_0000;
		for (int k = 1; k <= 20; k++) begin
			prod = 128'(term) * 128'(frac);
			term = prod[95:32] / 64'(k);
			if (k % 2 == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		r = sum;
		for (int j = 0; j < 16; j++) begin
			if (64'(j) < whole) begin
				prod = 128'(r) * 128'(E_INV_Q32);
				r    = prod[95:32];
			end
		end
		r = r + 64'h8000;
		return r[32:16];
	endfunction

	function automatic exp_tab_t build_exp_table();
		exp_tab_t t;
		for (int i = 0; i < EXP_TABLE_SIZE; i++)
			t[i] = exp_entry(i);
		return t;
	endfunction

	localparam exp_tab_t EXP_TABLE = build_exp_table();

	// weight for a Q16 exponent argument; zero at or above 16.0
	function automatic logic [16:0] exp_weight(logic [49:0] u);
		logic [32:0] p;
		p = 33'(u[19:0]) * 33'(EXP_TABLE_SIZE);
		if (u[49:20] != '0)
			return 17'd0;
		return EXP_TABLE[p[20 +: EXP_IW]];
	endfunction

endpackage

/* rtl/joint_bilateral_denoise_unit.sv */
// Joint bilateral denoiser top level: config registers, window sequencer,
// frame store, weight pipeline and shared divider. Uses jbd_pkg, jbd_frame_mem,
// jbd_div3, jbd_weight.
//
//  channel  signals                     direction
//  cfg      cfg_valid/cfg_ready         in   cfg_index, cfg_data
//  in       in_valid/in_ready           in   op, pixel_x/y, color, albedo, normal
//  out      out_valid/out_ready         out  out_x/y, out_red/green/blue
//
// Write item: stored in the frame store when taken. Compute item: center read, then
// for each of the (2*RADIUS+1)^2 window neighbors an address, read, sum and 24-step
// tone-map division on the shared divider, then averaging and inverse tone map.
// in_ready is high only while idle. A finished result waits in the output
// register; the next item is taken meanwhile. Reset clears control state only.
module joint_bilateral_denoise_unit #(
	parameter int MAX_WIDTH  = jbd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = jbd_pkg::MAX_HEIGHT_DEF,
	parameter int RADIUS     = jbd_pkg::RADIUS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [8:0]         pixel_x,
	input  logic [8:0]         pixel_y,
	input  logic [15:0]        color_red,
	input  logic [15:0]        color_green,
	input  logic [15:0]        color_blue,
	input  logic [11:0]        albedo_red,
	input  logic [11:0]        albedo_green,
	input  logic [11:0]        albedo_blue,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [8:0]         out_x,
	output logic [8:0]         out_y,
	output logic [15:0]        out_red,
	output logic [15:0]        out_green,
	output logic [15:0]        out_blue
);
	import jbd_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int OW    = $clog2(RADIUS + 1) + 1;
	localparam int D2_W  = $clog2(2 * RADIUS * RADIUS + 1);
	localparam int NB_W  = $clog2((2 * RADIUS + 1) * (2 * RADIUS + 1));
	localparam int WS_W  = 17 + NB_W;
	localparam int CS_W  = 41 + NB_W;
	localparam int SZ_W  = 14;
	localparam logic signed [OW-1:0] R_POS = OW'(RADIUS);
	localparam logic signed [OW-1:0] R_NEG = -R_POS;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_CENTER = 14'b00000000000010,
		S_CWAIT  = 14'b00000000000100,
		S_ADDR   = 14'b00000000001000,
		S_RDWAIT = 14'b00000000010000,
		S_SUM    = 14'b00000000100000,
		S_TONE   = 14'b00000001000000,
		S_AVG    = 14'b00000010000000,
		S_AVGW   = 14'b00000100000000,
		S_LUMF   = 14'b00001000000000,
		S_LUMS   = 14'b00010000000000,
		S_INVW   = 14'b00100000000000,
		S_OUT    = 14'b01000000000000,
		S_SPARE  = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [9:0]  fw_q, fh_q;
	logic [15:0] ssc_q, asc_q, nsc_q;

	logic signed [OW-1:0] ox_q, oy_q;
	logic [8:0]           x_q, y_q;
	logic                 out_valid_q;

	pixel_t                cen_q;
	logic [2:0][23:0]      sqa_q;
	logic [2:0][31:0]      sqn_q;
	logic [2:0][31:0]      lp_q;
	logic [2:0][15:0]      col_q;
	logic [25:0]           a2_q;
	logic [33:0]           n2_q;
	logic [D2_W-1:0]       d2_q;
	logic [WS_W-1:0]       wsum_q;
	logic [2:0][CS_W-1:0]  csum_q;
	logic [2:0][23:0]      f_q;
	logic [2:0][39:0]      fl_q;
	logic [2:0]            sat_q;
	logic [2:0][15:0]      res_q;
	logic [8:0]            out_x_q, out_y_q;
	logic [2:0][15:0]      out_c_q;

	logic [SZ_W-1:0]        weff, heff;
	logic signed [SZ_W-1:0] sx, sy;
	logic [SZ_W-1:0]        nx, ny;
	logic                   in_acc, wr_en, rd_en, in_frame, load;
	logic [AW-1:0]          wr_addr, rd_addr;
	pixel_t                 wr_px, rd_px;
	div_req_t               div_req;
	div_rsp_t               div_rsp;
	logic [16:0]            wt;
	logic [33:0]            lum_tone;
	logic [41:0]            lum_f;
	logic                   lum_high;
	logic [DIV_W-1:0]       inv_d;
	logic [2:0][48:0]       inv_num;
	logic [2:0]             inv_sat;
	logic [2:0][CS_W:0]     avg_num;
	logic signed [2*OW-1:0] ox2, oy2, d2_sum;

	// config
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= 10'd512;
			fh_q  <= 10'd512;
			ssc_q <= 16'd2048;
			asc_q <= 16'd1280;
			nsc_q <= 16'd12800;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  fw_q  <= cfg_data[9:0];
				CFG_FRAME_HEIGHT: fh_q  <= cfg_data[9:0];
				CFG_SPATIAL:      ssc_q <= cfg_data;
				CFG_ALBEDO:       asc_q <= cfg_data;
				CFG_NORMAL:       nsc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fw_q == '0)
			weff = SZ_W'(1);
		else if (SZ_W'(fw_q) > SZ_W'(MAX_WIDTH))
			weff = SZ_W'(MAX_WIDTH);
		else
			weff = SZ_W'(fw_q);
		if (fh_q == '0)
			heff = SZ_W'(1);
		else if (SZ_W'(fh_q) > SZ_W'(MAX_HEIGHT))
			heff = SZ_W'(MAX_HEIGHT);
		else
			heff = SZ_W'(fh_q);
	end

	// input side
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign in_frame = (SZ_W'(pixel_x) < weff) && (SZ_W'(pixel_y) < heff);
	assign wr_en    = in_acc && (op == OP_WRITE) && (SZ_W'(pixel_x) < SZ_W'(MAX_WIDTH)) &&
		(SZ_W'(pixel_y) < SZ_W'(MAX_HEIGHT));
	assign wr_addr  = AW'(AW'(pixel_y) * AW'(MAX_WIDTH) + AW'(pixel_x));
	assign wr_px.color  = {color_blue, color_green, color_red};
	assign wr_px.albedo = {albedo_blue, albedo_green, albedo_red};
	assign wr_px.normal = {normal_z, normal_y, normal_x};

	// neighbor address, clamped to the frame
	always_comb begin
		sx = $signed(SZ_W'(x_q)) + SZ_W'(ox_q);
		sy = $signed(SZ_W'(y_q)) + SZ_W'(oy_q);
		if (sx < 0)
			nx = '0;
		else if (sx >= $signed(weff))
			nx = weff - 1'b1;
		else
			nx = SZ_W'(sx);
		if (sy < 0)
			ny = '0;
		else if (sy >= $signed(heff))
			ny = heff - 1'b1;
		else
			ny = SZ_W'(sy);
	end

	assign rd_en   = (state_q == S_CENTER) || (state_q == S_ADDR);
	assign rd_addr = AW'(AW'(ny) * AW'(MAX_WIDTH) + AW'(nx));

	jbd_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_px),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_px)
	);

	jbd_weight #(.D2_W(D2_W)) u_weight (
		.clk           (clk),
		.d2            (d2_q),
		.a2            (a2_q),
		.n2            (n2_q),
		.spatial_scale (ssc_q),
		.albedo_scale  (asc_q),
		.normal_scale  (nsc_q),
		.wt            (wt)
	);

	jbd_div3 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// datapath terms
	always_comb begin
		ox2      = ox_q * ox_q;
		oy2      = oy_q * oy_q;
		d2_sum   = ox2 + oy2;
		lum_tone = 34'(lp_q[0]) + 34'(lp_q[1]) + 34'(lp_q[2]) + 34'h100_0000;
		lum_f    = 42'(fl_q[0]) + 42'(fl_q[1]) + 42'(fl_q[2]);
		lum_high = (lum_f[41:32] != '0);
		inv_d    = 33'h1_0000_0000 - {1'b0, lum_f[31:0]};
		for (int ch = 0; ch < 3; ch++) begin
			avg_num[ch] = (CS_W+1)'(csum_q[ch]) + (CS_W+1)'(wsum_q >> 1);
			inv_num[ch] = {1'b0, f_q[ch], 24'd0} + 49'(inv_d >> 1);
			inv_sat[ch] = inv_num[ch][48:16] >= inv_d;
		end
	end

	always_comb begin
		div_req = '0;
		if (state_q == S_SUM) begin
			div_req.start   = 1'b1;
			div_req.steps   = STEPS_TONE;
			div_req.divisor = DIV_W'(lum_tone);
			for (int ch = 0; ch < 3; ch++)
				div_req.rem_init[ch] = DIV_W'({col_q[ch], 8'd0});
		end else if (state_q == S_AVG) begin
			div_req.start   = 1'b1;
			div_req.steps   = STEPS_AVG;
			div_req.divisor = DIV_W'(wsum_q);
			for (int ch = 0; ch < 3; ch++) begin
				div_req.rem_init[ch] = DIV_W'(avg_num[ch] >> 24);
				div_req.low_init[ch] = avg_num[ch][23:0];
			end
		end else if (state_q == S_LUMS && !lum_high) begin
			div_req.start   = 1'b1;
			div_req.steps   = STEPS_INV;
			div_req.divisor = inv_d;
			for (int ch = 0; ch < 3; ch++) begin
				div_req.rem_init[ch] = inv_sat[ch] ? '0 : inv_num[ch][48:16];
				div_req.low_init[ch] = {inv_num[ch][15:0], 8'd0};
			end
		end
	end

	assign load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ox_q        <= '0;
			oy_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && op == OP_COMPUTE && in_frame) begin
						state_q <= S_CENTER;
						ox_q    <= '0;
						oy_q    <= '0;
					end
				end
				S_CENTER: state_q <= S_CWAIT;
				S_CWAIT: begin
					ox_q    <= R_NEG;
					oy_q    <= R_NEG;
					state_q <= S_ADDR;
				end
				S_ADDR:   state_q <= S_RDWAIT;
				S_RDWAIT: state_q <= S_SUM;
				S_SUM:    state_q <= S_TONE;
				S_TONE: begin
					if (div_rsp.done) begin
						if (ox_q == R_POS) begin
							ox_q <= R_NEG;
							if (oy_q == R_POS) begin
								state_q <= S_AVG;
							end else begin
								oy_q    <= oy_q + 1'b1;
								state_q <= S_ADDR;
							end
						end else begin
							ox_q    <= ox_q + 1'b1;
							state_q <= S_ADDR;
						end
					end
				end
				S_AVG: state_q <= S_AVGW;
				S_AVGW: begin
					if (div_rsp.done)
						state_q <= S_LUMF;
				end
				S_LUMF: state_q <= S_LUMS;
				S_LUMS: state_q <= lum_high ? S_OUT : S_INVW;
				S_INVW: begin
					if (div_rsp.done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= pixel_x;
			y_q <= pixel_y;
		end
		if (load) begin
			out_x_q <= x_q;
			out_y_q <= y_q;
			out_c_q <= res_q;
		end
		unique case (state_q)
			S_CWAIT: begin
				cen_q  <= rd_px;
				wsum_q <= '0;
				csum_q <= '0;
			end
			S_RDWAIT: begin
				for (int ch = 0; ch < 3; ch++) begin
					sqa_q[ch] <= 24'(($signed({1'b0, cen_q.albedo[ch]}) -
						$signed({1'b0, rd_px.albedo[ch]})) *
						($signed({1'b0, cen_q.albedo[ch]}) -
						$signed({1'b0, rd_px.albedo[ch]})));
					sqn_q[ch] <= 32'(($signed({cen_q.normal[ch][15], cen_q.normal[ch]}) -
						$signed({rd_px.normal[ch][15], rd_px.normal[ch]})) *
						($signed({cen_q.normal[ch][15], cen_q.normal[ch]}) -
						$signed({rd_px.normal[ch][15], rd_px.normal[ch]})));
					lp_q[ch]  <= 32'(rd_px.color[ch]) * 32'(LUM_COEF[ch]);
					col_q[ch] <= rd_px.color[ch];
				end
			end
			S_SUM: begin
				a2_q <= 26'(sqa_q[0]) + 26'(sqa_q[1]) + 26'(sqa_q[2]);
				n2_q <= 34'(sqn_q[0]) + 34'(sqn_q[1]) + 34'(sqn_q[2]);
				d2_q <= D2_W'(d2_sum);
			end
			S_TONE: begin
				if (div_rsp.done) begin
					wsum_q <= wsum_q + WS_W'(wt);
					for (int ch = 0; ch < 3; ch++)
						csum_q[ch] <= csum_q[ch] +
							CS_W'(41'(wt) * 41'(div_rsp.quot[ch]));
				end
			end
			S_AVGW: begin
				if (div_rsp.done)
					f_q <= div_rsp.quot;
			end
			S_LUMF: begin
				for (int ch = 0; ch < 3; ch++)
					fl_q[ch] <= 40'(f_q[ch]) * 40'(LUM_COEF[ch]);
			end
			S_LUMS: begin
				sat_q <= inv_sat;
				if (lum_high) begin
					for (int ch = 0; ch < 3; ch++)
						res_q[ch] <= (f_q[ch] != '0) ? 16'hFFFF : 16'h0000;
				end
			end
			S_INVW: begin
				if (div_rsp.done) begin
					for (int ch = 0; ch < 3; ch++)
						res_q[ch] <= sat_q[ch] ? 16'hFFFF : div_rsp.quot[ch][15:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_red   = out_c_q[0];
	assign out_green = out_c_q[1];
	assign out_blue  = out_c_q[2];

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_TONE || state_q == S_AVGW || state_q == S_INVW))
		else $error("divider done outside a wait state");

	a_compute_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_COMPUTE && in_frame) |=> (state_q == S_CENTER && !in_ready))
		else $error("compute item did not start the window");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (out_valid && state_q == S_IDLE))
		else $error("result not presented after load");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TONE) |-> (ox_q >= R_NEG && ox_q <= R_POS && oy_q >= R_NEG &&
		oy_q <= R_POS))
		else $error("window offset out of range");

endmodule

/* rtl/jbd_frame_mem.sv */
// Frame store: color, albedo and normal of every pixel in one wide memory.
// One write port, one registered read port. Uses jbd_pkg.
module jbd_frame_mem #(
	parameter int DEPTH = 262144,
	parameter int AW    = 18
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  jbd_pkg::pixel_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output jbd_pkg::pixel_t rd_data
);
	import jbd_pkg::*;

	pixel_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/jbd_div3.sv */
// Shared restoring divider, one quotient bit per cycle on three lanes that
// share a divisor. Caller supplies the upper remainder and low numerator bits.
// Uses jbd_pkg.
module jbd_div3 (
	input  logic              clk,
	input  logic              arst_n,
	input  jbd_pkg::div_req_t req,
	output jbd_pkg::div_rsp_t rsp
);
	import jbd_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [DIV_W-1:0]      div_q;
	logic [2:0][DIV_W-1:0] rem_q;
	logic [2:0][QUO_W-1:0] low_q;
	logic [2:0][DIV_W:0]   r2;
	logic [2:0]            qb;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			r2[l] = {rem_q[l], low_q[l][QUO_W-1]};
			qb[l] = r2[l] >= {1'b0, div_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.divisor;
			rem_q <= req.rem_init;
			low_q <= req.low_init;
		end else if (busy_q) begin
			for (int l = 0; l < 3; l++) begin
				rem_q[l] <= qb[l] ? DIV_W'(r2[l] - {1'b0, div_q}) : r2[l][DIV_W-1:0];
				low_q[l] <= {low_q[l][QUO_W-2:0], qb[l]};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = low_q;

endmodule

/* rtl/jbd_weight.sv */
// Neighbor weight pipeline: exponent arguments, table lookups, weight product.
// Four register stages, free running. Uses jbd_pkg (exp_weight).
module jbd_weight #(
	parameter int D2_W = 8
) (
	input  logic            clk,
	input  logic [D2_W-1:0] d2,
	input  logic [25:0]     a2,
	input  logic [33:0]     n2,
	input  logic [15:0]     spatial_scale,
	input  logic [15:0]     albedo_scale,
	input  logic [15:0]     normal_scale,
	output logic [16:0]     wt
);
	import jbd_pkg::*;

	logic [D2_W+15:0] u0_s1;
	logic [25:0]      u1_s1;
	logic [29:0]      u2_s1;
	logic [16:0]      w0_s2, w1_s2, w2_s2, w2_s3;
	logic [16:0]      w01_s3;
	logic [16:0]      wt_s4;
	logic [41:0]      p1;
	logic [49:0]      p2;
	logic [33:0]      m01, m2;

	assign p1  = 42'(a2) * 42'(albedo_scale);
	assign p2  = 50'(n2) * 50'(normal_scale);
	assign m01 = 34'(w0_s2) * 34'(w1_s2);
	assign m2  = 34'(w01_s3) * 34'(w2_s3);

	always_ff @(posedge clk) begin
		u0_s1  <= (D2_W+16)'(d2) * (D2_W+16)'(spatial_scale);
		u1_s1  <= p1[41:16];
		u2_s1  <= p2[49:20];
		w0_s2  <= exp_weight(50'(u0_s1));
		w1_s2  <= exp_weight(50'(u1_s1));
		w2_s2  <= exp_weight(50'(u2_s1));
		w01_s3 <= m01[32:16];
		w2_s3  <= w2_s2;
		wt_s4  <= m2[32:16];
	end

	assign wt = wt_s4;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for joint_bilateral_denoise_unit: pixel writes and
// denoise requests over valid/ready, results checked against a fixed-point filter model.
// Depends on rtl/jbd_pkg.sv and the RTL of joint_bilateral_denoise_unit.
module tb_top;
	import jbd_pkg::*;

	localparam int       NPIX        = 512 * 512;
	localparam int       WIN_R       = 8;
	localparam int       SETTLE      = 9000;
	localparam longint   CYCLE_LIMIT = 20000000;
	localparam longint unsigned ONE32 = 64'h1_0000_0000;
	localparam longint unsigned ONE24 = 64'h100_0000;

	typedef struct packed {
		op_t        op;
		logic [8:0] x;
		logic [8:0] y;
		pixel_t     px;
	} pix_item_t;

	typedef struct packed {
		logic [8:0]       x;
		logic [8:0]       y;
		logic [2:0][15:0] rgb;
	} denoised_t;

	typedef enum int {ROW_PRED, ROW_TYPED, ROW_NONE} row_kind_t;

	typedef struct {
		pix_item_t  it;
		row_kind_t  kind;
		denoised_t  res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_index_t cfg_index = CFG_FRAME_WIDTH;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	op_t op = OP_WRITE;
	logic [8:0] pixel_x = '0, pixel_y = '0;
	logic [15:0] color_red = '0, color_green = '0, color_blue = '0;
	logic [11:0] albedo_red = '0, albedo_green = '0, albedo_blue = '0;
	logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [8:0] out_x, out_y;
	logic [15:0] out_red, out_green, out_blue;

	joint_bilateral_denoise_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.color_red(color_red), .color_green(color_green), .color_blue(color_blue),
		.albedo_red(albedo_red), .albedo_green(albedo_green), .albedo_blue(albedo_blue),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue)
	);

	always #6 clk = ~clk;

	// shadow state
	pixel_t          frame_px [NPIX];
	bit              written [NPIX];
	longint unsigned exp_lut [256];
	logic [9:0]      frame_w_reg = 10'd512, frame_h_reg = 10'd512;
	logic [15:0]     spatial_k = 16'd2048, albedo_k = 16'd1280, normal_k = 16'd12800;
	denoised_t       pending_pixels [$];
	int              mismatches = 0;
	longint          cycles = 0;
	bit              no_gaps = 0;

	function automatic longint unsigned exp_neg(longint unsigned xq);
		longint unsigned whole, frac, term, r;
		longint sum;
		whole = xq >> 32;
		frac  = xq & 64'hFFFF_FFFF;
		term  = ONE32;
		sum   = longint'(ONE32);
		for (int k = 1; k <= 20; k++) begin
			term = ((term * frac) >> 32) / longint'(k);
			if (k & 1) sum -= longint'(term);
			else sum += longint'(term);
		end
		r = longint'(sum);
		for (longint unsigned i = 0; i < whole; i++) r = (r * 64'd1580030169) >> 32;
		return r;
	endfunction

	function automatic longint unsigned lut_weight(longint unsigned u);
		if (u >= (64'd1 << 20)) return 0;
		return exp_lut[(u * 256) >> 20];
	endfunction

	function automatic int eff_dim(logic [9:0] v);
		if (v == 0) return 1;
		return (v > 512) ? 512 : int'(v);
	endfunction

	function automatic int clampc(int v, int n);
		if (v < 0) return 0;
		if (v >= n) return n - 1;
		return v;
	endfunction

	function automatic bit window_ready(int x, int y);
		int w, h;
		w = eff_dim(frame_w_reg);
		h = eff_dim(frame_h_reg);
		for (int oy = -WIN_R; oy <= WIN_R; oy++)
			for (int ox = -WIN_R; ox <= WIN_R; ox++)
				if (!written[clampc(y + oy, h) * 512 + clampc(x + ox, w)]) return 0;
		return 1;
	endfunction

	function automatic denoised_t filter_pixel(int x, int y);
		longint unsigned csum [3], f [3], t [3];
		longint unsigned wsum, wt, a2, n2, d2, lum, den, v, coef [3];
		longint da, dn;
		int w, h, ci, ni;
		denoised_t res;
		coef = '{64'd13932, 64'd46872, 64'd4732};
		csum = '{0, 0, 0};
		wsum = 0;
		w = eff_dim(frame_w_reg);
		h = eff_dim(frame_h_reg);
		ci = y * 512 + x;
		for (int oy = -WIN_R; oy <= WIN_R; oy++) begin
			for (int ox = -WIN_R; ox <= WIN_R; ox++) begin
				ni = clampc(y + oy, h) * 512 + clampc(x + ox, w);
				d2 = longint'(ox * ox + oy * oy);
				a2 = 0;
				n2 = 0;
				for (int ch = 0; ch < 3; ch++) begin
					da = longint'(frame_px[ci].albedo[ch]) - longint'(frame_px[ni].albedo[ch]);
					dn = longint'($signed(frame_px[ci].normal[ch]))
						- longint'($signed(frame_px[ni].normal[ch]));
					a2 += da * da;
					n2 += dn * dn;
				end
				wt = (lut_weight(d2 * spatial_k) * lut_weight((a2 * albedo_k) >> 16)) >> 16;
				wt = (wt * lut_weight((n2 * normal_k) >> 20)) >> 16;
				lum = 0;
				for (int ch = 0; ch < 3; ch++) lum += frame_px[ni].color[ch] * coef[ch];
				for (int ch = 0; ch < 3; ch++)
					t[ch] = (longint'(frame_px[ni].color[ch]) << 32) / (lum + ONE24);
				wsum += wt;
				for (int ch = 0; ch < 3; ch++) csum[ch] += wt * t[ch];
			end
		end
		res.x = 9'(x);
		res.y = 9'(y);
		if (wsum == 0) begin
			res.rgb = '0;
			return res;
		end
		lum = 0;
		for (int ch = 0; ch < 3; ch++) begin
			f[ch] = (csum[ch] + wsum / 2) / wsum;
			lum += f[ch] * coef[ch];
		end
		for (int ch = 0; ch < 3; ch++) begin
			if (lum >= ONE32) begin
				v = (f[ch] != 0) ? 65535 : 0;
			end else begin
				den = ONE32 - lum;
				v = ((f[ch] << 24) + den / 2) / den;
				if (v > 65535) v = 65535;
			end
			res.rgb[ch] = v[15:0];
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input pix_item_t it, input row_kind_t kind, input denoised_t typed);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= it.op;
		pixel_x <= it.x;
		pixel_y <= it.y;
		color_red <= it.px.color[0];
		color_green <= it.px.color[1];
		color_blue <= it.px.color[2];
		albedo_red <= it.px.albedo[0];
		albedo_green <= it.px.albedo[1];
		albedo_blue <= it.px.albedo[2];
		normal_x <= it.px.normal[0];
		normal_y <= it.px.normal[1];
		normal_z <= it.px.normal[2];
		do @(posedge clk); while (!in_ready);
		if (it.op == OP_WRITE) begin
			frame_px[it.y * 512 + it.x] = it.px;
			written[it.y * 512 + it.x] = 1;
		end else if (it.x < eff_dim(frame_w_reg) && it.y < eff_dim(frame_h_reg)) begin
			pending_pixels.push_back(kind == ROW_TYPED ? typed : filter_pixel(it.x, it.y));
		end
	endtask

	task automatic wait_idle();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FRAME_WIDTH:  frame_w_reg = val[9:0];
			CFG_FRAME_HEIGHT: frame_h_reg = val[9:0];
			CFG_SPATIAL:      spatial_k = val;
			CFG_ALBEDO:       albedo_k = val;
			CFG_NORMAL:       normal_k = val;
			default: ;
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	function automatic pixel_t rand_pixel(logic [11:0] alb0, int nrm0);
		pixel_t p;
		int n;
		for (int ch = 0; ch < 3; ch++) begin
			case ($urandom_range(0, 7))
				0: p.color[ch] = 16'($urandom_range(0, 65535));
				1: p.color[ch] = 16'd0;
				default: p.color[ch] = 16'($urandom_range(0, 2047));
			endcase
			p.albedo[ch] = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
				: alb0 ^ 12'($urandom_range(0, 127));
			case ($urandom_range(0, 11))
				0: p.normal[ch] = 16'($urandom_range(0, 65535));
				1: p.normal[ch] = ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
				default: begin
					n = nrm0 + int'($urandom_range(0, 800)) - 400;
					p.normal[ch] = 16'(n);
				end
			endcase
		end
		return p;
	endfunction

	task automatic run_phase(input logic [15:0] wv, input logic [15:0] hv,
			input logic [15:0] sk, input logic [15:0] ak, input logic [15:0] nk,
			input int rx, input int ry, input int rw, input int rh, input int count);
		pix_item_t it;
		logic [11:0] alb0;
		int nrm0, r, w, h;
		denoised_t none;
		none = '0;
		wait_idle();
		write_reg(CFG_FRAME_WIDTH, wv);
		write_reg(CFG_FRAME_HEIGHT, hv);
		write_reg(CFG_SPATIAL, sk);
		write_reg(CFG_ALBEDO, ak);
		write_reg(CFG_NORMAL, nk);
		w = eff_dim(frame_w_reg);
		h = eff_dim(frame_h_reg);
		alb0 = 12'($urandom_range(0, 4095));
		nrm0 = int'($urandom_range(0, 30000)) - 15000;
		no_gaps = ($urandom_range(0, 2) == 0);
		for (int n = 0; n < count; n++) begin
			if (n == count / 2) begin
				// hold off until the block has drained
				@(negedge clk) in_valid <= 1'b0;
				while (pending_pixels.size() != 0) @(posedge clk);
			end
			it.px = rand_pixel(alb0, nrm0);
			it.op = OP_WRITE;
			r = $urandom_range(0, 99);
			if (r < 6) begin
				it.x = 9'($urandom_range(0, 511));
				it.y = 9'($urandom_range(0, 511));
			end else begin
				it.x = 9'(rx + int'($urandom_range(0, rw - 1)));
				it.y = 9'(ry + int'($urandom_range(0, rh - 1)));
				if (r < 10 && (w < 512 || h < 512)) begin
					it.op = OP_COMPUTE;
					if (w < 512) it.x = 9'($urandom_range(w, 511));
					else it.y = 9'($urandom_range(h, 511));
				end else if (r < 28 && window_ready(it.x, it.y)) begin
					it.op = OP_COMPUTE;
				end else begin
					for (int k = 0; k < 4 && written[it.y * 512 + it.x]; k++) begin
						it.x = 9'(rx + int'($urandom_range(0, rw - 1)));
						it.y = 9'(ry + int'($urandom_range(0, rh - 1)));
					end
				end
			end
			send_item(it, ROW_PRED, none);
		end
	endtask

	function automatic stim_row_t mk_row(op_t o, int x, int y, logic [47:0] c,
			logic [35:0] a, logic [47:0] nv, row_kind_t k);
		stim_row_t s;
		s.it.op = o;
		s.it.x = 9'(x);
		s.it.y = 9'(y);
		s.it.px.color = c;
		s.it.px.albedo = a;
		s.it.px.normal = nv;
		s.kind = k;
		s.res = '0;
		s.res.x = 9'(x);
		s.res.y = 9'(y);
		return s;
	endfunction

	// monitor
	always @(posedge clk) begin
		denoised_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d rgb=%h %h %h", $realtime,
					out_x, out_y, out_red, out_green, out_blue);
				mismatches++;
			end else begin
				e = pending_pixels.pop_front();
				if ({out_x, out_y, out_blue, out_green, out_red} !== e) begin
					$display("%0t: mismatch expected x=%0d y=%0d rgb=%h %h %h",
						$realtime, e.x, e.y, e.rgb[0], e.rgb[1], e.rgb[2]);
					$display("%0t:          actual   x=%0d y=%0d rgb=%h %h %h",
						$realtime, out_x, out_y, out_red, out_green, out_blue);
					mismatches++;
				end
			end
		end
	end

	// receiver stalls
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
					: $urandom_range(1, 4);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [$];
		for (int i = 0; i < 256; i++) begin
			longint unsigned r;
			r = exp_neg((longint'(i) << 36) / 256);
			exp_lut[i] = (r + 64'h8000) >> 16;
		end
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// 1x1 frame: width 0 acts as 1, every neighbor is the center pixel
		write_reg(CFG_FRAME_WIDTH, 16'd0);
		write_reg(CFG_FRAME_HEIGHT, 16'd1);
		rows.push_back(mk_row(OP_WRITE, 0, 0, '0, '0, '0, ROW_PRED));
		rows.push_back(mk_row(OP_COMPUTE, 0, 0, '0, '0, '0, ROW_TYPED));
		rows.push_back(mk_row(OP_COMPUTE, 1, 0, '0, '0, '0, ROW_NONE));
		rows.push_back(mk_row(OP_COMPUTE, 0, 1, '0, '0, '0, ROW_NONE));
		rows.push_back(mk_row(OP_COMPUTE, 511, 511, '1, '1, '1, ROW_NONE));
		rows.push_back(mk_row(OP_WRITE, 0, 0, '1, '1, {16'h0000, 16'hC000, 16'h4000}, ROW_PRED));
		rows.push_back(mk_row(OP_COMPUTE, 0, 0, '0, '0, '0, ROW_PRED));
		rows.push_back(mk_row(OP_WRITE, 0, 0, {16'd0, 16'd0, 16'd256}, 36'h123456789, '0,
			ROW_PRED));
		rows.push_back(mk_row(OP_COMPUTE, 0, 0, '0, '0, '0, ROW_PRED));
		rows.push_back(mk_row(OP_WRITE, 511, 511, {16'd3, 16'd2, 16'd1},
			{12'hFFF, 12'd2, 12'd1}, {16'h0001, 16'h7FFF, 16'h8000}, ROW_PRED));
		rows.push_back(mk_row(OP_WRITE, 511, 0, {3{16'hAAAA}}, {3{12'hAAA}},
			{3{16'h5555}}, ROW_PRED));
		rows.push_back(mk_row(OP_WRITE, 0, 511, {3{16'h5555}}, {3{12'h555}},
			{3{16'hAAAA}}, ROW_PRED));
		rows.push_back(mk_row(OP_WRITE, 255, 256, {16'h8000, 16'h00FF, 16'h7F00},
			{12'h800, 12'h0F0, 12'h70F}, {16'hC000, 16'h4000, 16'h0000}, ROW_PRED));
		rows.push_back(mk_row(OP_WRITE, 0, 0, {16'hFFFF, 16'd0, 16'd0}, '0,
			{16'h4000, 16'd0, 16'd0}, ROW_PRED));
		rows.push_back(mk_row(OP_COMPUTE, 0, 0, '0, '0, '0, ROW_PRED));
		rows.push_back(mk_row(OP_WRITE, 0, 0, {16'd0, 16'h0100, 16'd0}, {3{12'h800}},
			{16'd0, 16'h4000, 16'd0}, ROW_PRED));
		rows.push_back(mk_row(OP_COMPUTE, 0, 0, '0, '0, '0, ROW_PRED));
		foreach (rows[i]) send_item(rows[i].it, rows[i].kind, rows[i].res);

		run_phase(16'd10, 16'd6, 16'd2048, 16'd1280, 16'd12800, 0, 0, 10, 6, 90);
		run_phase(16'd1023, 16'd1, 16'd0, 16'd0, 16'd0, 496, 0, 16, 1, 70);
		run_phase(16'd512, 16'd512, 16'hFFFF, 16'hFFFF, 16'hFFFF, 503, 503, 9, 9, 120);
		run_phase(16'd3, 16'd17, 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			0, 0, 3, 17, 85);
		run_phase(16'd1, 16'd512, 16'($urandom_range(0, 8192)),
			16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
			0, 0, 1, 16, 70);
		run_phase(16'd9, 16'd9, 16'($urandom_range(0, 4096)), 16'($urandom_range(0, 2048)),
			16'($urandom_range(0, 8192)), 0, 0, 9, 9, 100);

		wait_idle();
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
